// ===== hw/rtl/fcc_pkg.sv =====
`default_nettype none

package fcc_pkg;

  // Field widths taken from the interface definition.
  localparam int LVL_W      = 12;
  localparam int TOT_W      = 14;
  localparam int DIFF_W     = 14;
  localparam int ANG_W      = 14;
  localparam int PW_W       = 11;
  localparam int AMB_REG_W  = 10;
  localparam int GAIN_W     = 10;
  localparam int DB_W       = 13;
  localparam int CORR_W     = 9;
  localparam int SETTLE_W   = 3;

  // Divider operand widths.
  localparam int NUM_W      = 32;
  localparam int DIVD_W     = 32;
  localparam int DIVS_W     = 19;
  localparam int QUO_W      = 14;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Behavioural constants.
  localparam int SAMPLES_PER_READ = 3;
  localparam int SETTLE_TICKS     = 3;
  localparam int ANGLE_MAX        = 6554;
  localparam logic [PW_W-1:0] NEUTRAL_US = 11'd1500;

  // Register reset values.
  localparam logic [GAIN_W-1:0] GAIN_RST  = 10'd128;
  localparam logic [DB_W-1:0]   DB_RST    = 13'd384;
  localparam logic [CORR_W-1:0] MIN_RST   = 9'd67;
  localparam logic [CORR_W-1:0] LIMIT_RST = 9'd350;

  // Register index map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMB0     = 3'd0,
    REG_AMB1     = 3'd1,
    REG_AMB2     = 3'd2,
    REG_AMB3     = 3'd3,
    REG_GAIN     = 3'd4,
    REG_DEADBAND = 3'd5,
    REG_MIN_OUT  = 3'd6,
    REG_LIMIT    = 3'd7
  } cfg_reg_t;

  // Current register contents.
  typedef struct packed {
    logic [3:0][AMB_REG_W-1:0] ambient;
    logic [GAIN_W-1:0]         gain;
    logic [DB_W-1:0]           deadband;
    logic [CORR_W-1:0]         min_out;
    logic [CORR_W-1:0]         limit;
  } cfg_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcc_cfg_regs.sv =====
`default_nettype none

module fcc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [fcc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [fcc_pkg::CFG_DATA_W-1:0] wr_data,
  output fcc_pkg::cfg_t                       cfg
);
  import fcc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; each field keeps only its own width.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_AMB0:     cfg_nxt.ambient[0] = wr_data[AMB_REG_W-1:0];
        REG_AMB1:     cfg_nxt.ambient[1] = wr_data[AMB_REG_W-1:0];
        REG_AMB2:     cfg_nxt.ambient[2] = wr_data[AMB_REG_W-1:0];
        REG_AMB3:     cfg_nxt.ambient[3] = wr_data[AMB_REG_W-1:0];
        REG_GAIN:     cfg_nxt.gain       = wr_data[GAIN_W-1:0];
        REG_DEADBAND: cfg_nxt.deadband   = wr_data[DB_W-1:0];
        REG_MIN_OUT:  cfg_nxt.min_out    = wr_data[CORR_W-1:0];
        REG_LIMIT:    cfg_nxt.limit      = wr_data[CORR_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ambient  <= '0;
      cfg_r.gain     <= GAIN_RST;
      cfg_r.deadband <= DB_RST;
      cfg_r.min_out  <= MIN_RST;
      cfg_r.limit    <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fcc_divider.sv =====
`default_nettype none

module fcc_divider (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  fcc_pkg::div_req_t  req,
  output fcc_pkg::div_rsp_t  rsp
);
  import fcc_pkg::*;

  localparam int DVS_W = DIVS_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             ge;
  logic [DVS_W:0]   rem_ext;

  // One compare and subtract per cycle, most significant quotient bit first.
  assign rem_ext = (DVS_W + 1)'(rem_r);
  assign ge      = rem_ext >= (DVS_W + 1)'(dvs_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      rem_nxt  = req.dividend;
      dvs_nxt  = DVS_W'(req.divisor) << (QUO_W - 1);
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = DIVD_W'(rem_ext - (DVS_W + 1)'(dvs_r));
      end
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/flame_centering_controller_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// in_      | input     | in_valid / in_stall        | in_sum_sensor0..3
// out_     | output    | out_valid / out_stall      | out_pulse_width, out_angle_q8,
//          |           |                            | out_flame_absent, out_centred
// cfg_     | input     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// out_valid rises in ST_OUT, which follows ST_SUM for a tick with no flame,
// ST_CMUL for a tick that ends centred and ST_CORR otherwise; the bearing
// filter waits in ST_DIVW on the serial divider, one quotient bit per cycle.
// One tick is worked at a time: in_stall is high from the input transfer
// until the result transfer, and out_stall simply holds the result. The next
// input transfer can follow in the cycle after the result transfer.
// Synchronous active-low reset clears state, filter and settle count and
// loads the register defaults; cfg_ready is always high.
`default_nettype none

module flame_centering_controller_core #(
  parameter int SAMPLES_PER_READ = fcc_pkg::SAMPLES_PER_READ
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [fcc_pkg::LVL_W-1:0]      in_sum_sensor0,
  input  wire logic [fcc_pkg::LVL_W-1:0]      in_sum_sensor1,
  input  wire logic [fcc_pkg::LVL_W-1:0]      in_sum_sensor2,
  input  wire logic [fcc_pkg::LVL_W-1:0]      in_sum_sensor3,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [fcc_pkg::PW_W-1:0]       out_pulse_width,
  output      logic signed [fcc_pkg::ANG_W-1:0] out_angle_q8,
  output      logic                           out_flame_absent,
  output      logic                           out_centred,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [fcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fcc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcc_pkg::*;

  localparam int AMB_W   = AMB_REG_W + $clog2(SAMPLES_PER_READ + 1);
  localparam int CMP_W   = (AMB_W > LVL_W) ? AMB_W : LVL_W;
  localparam int MPROD_W = TOT_W + 1 + ANG_W;
  localparam int GPROD_W = GAIN_W + 1 + ANG_W;
  localparam int PABS_W  = GPROD_W - 1;
  localparam int DEN_W   = DIVS_W - 1;
  localparam int LIM_W   = CORR_W + 12;
  localparam logic signed [ANG_W-1:0] ANGLE_LIM = ANG_W'(ANGLE_MAX);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SUM  = 9'b000000010,
    ST_MUL  = 9'b000000100,
    ST_NUM  = 9'b000001000,
    ST_DIVS = 9'b000010000,
    ST_DIVW = 9'b000100000,
    ST_CMUL = 9'b001000000,
    ST_CORR = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0][LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [LVL_W-1:0]           in_sum [4];
  logic [CMP_W-1:0]           amb_scaled [4];
  logic [CMP_W-1:0]           sum_ext [4];
  logic [TOT_W-1:0]           total_r, total_nxt;
  logic signed [DIFF_W-1:0]   diff_r, diff_nxt;
  logic signed [MPROD_W-1:0]  mprod_r, mprod_nxt;
  logic signed [NUM_W-1:0]    num_r, num_nxt;
  logic [NUM_W-1:0]           num_mag;
  logic [DEN_W-1:0]           den;
  logic signed [ANG_W-1:0]    filt_r, filt_nxt;
  logic [SETTLE_W-1:0]        settle_r, settle_nxt;
  logic [SETTLE_W-1:0]        settle_inc;
  logic signed [GPROD_W-1:0]  gprod_r, gprod_nxt;
  logic [ANG_W-1:0]           ang_abs;
  logic                       p_neg;
  logic [PABS_W-1:0]          p_abs;
  logic [PABS_W-1:0]          p_clamp;
  logic [PABS_W-1:0]          lim_q12;
  logic [PABS_W-1:0]          min_q12;
  logic [CORR_W-1:0]          corr;
  logic [PW_W-1:0]            pw_r, pw_nxt;
  logic signed [ANG_W-1:0]    ang_out_r, ang_out_nxt;
  logic                       nf_r, nf_nxt;
  logic                       cen_r, cen_nxt;

  fcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fcc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  assign in_sum[0] = in_sum_sensor0;
  assign in_sum[1] = in_sum_sensor1;
  assign in_sum[2] = in_sum_sensor2;
  assign in_sum[3] = in_sum_sensor3;

  // Ambient subtraction per sensor, clamped at zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      amb_scaled[i] = CMP_W'(cfg.ambient[i]) * CMP_W'(SAMPLES_PER_READ);
      sum_ext[i]    = CMP_W'(in_sum[i]);
      if (sum_ext[i] > amb_scaled[i]) begin
        lvl_nxt[i] = LVL_W'(sum_ext[i] - amb_scaled[i]);
      end else begin
        lvl_nxt[i] = '0;
      end
    end
  end

  // Divider operands: round to nearest as (2|num| + den) / (2 den).
  assign num_mag          = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign den              = (DEN_W'(total_r) << 3) + (DEN_W'(total_r) << 1);
  assign div_req.start    = (state_r == ST_DIVS);
  assign div_req.dividend = (num_mag << 1) + DIVD_W'(den);
  assign div_req.divisor  = {den, 1'b0};

  // Correction clamp and minimum magnitude, in Q12 microseconds.
  assign ang_abs    = filt_r[ANG_W-1] ? ANG_W'(-filt_r) : ANG_W'(filt_r);
  assign settle_inc = settle_r + 1'b1;
  assign p_neg      = gprod_r[GPROD_W-1];
  assign p_abs      = p_neg ? PABS_W'(-gprod_r) : PABS_W'(gprod_r);
  assign lim_q12    = PABS_W'({cfg.limit, 12'b0});
  assign min_q12    = PABS_W'({cfg.min_out, 12'b0});

  always_comb begin
    p_clamp = (p_abs > lim_q12) ? lim_q12 : p_abs;
    if ((p_clamp != '0) && (p_clamp < min_q12)) begin
      p_clamp = min_q12;
    end
    corr = p_clamp[LIM_W-1:12];
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    diff_nxt    = diff_r;
    mprod_nxt   = mprod_r;
    num_nxt     = num_r;
    filt_nxt    = filt_r;
    settle_nxt  = settle_r;
    gprod_nxt   = gprod_r;
    pw_nxt      = pw_r;
    ang_out_nxt = ang_out_r;
    nf_nxt      = nf_r;
    cen_nxt     = cen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        total_nxt = TOT_W'(lvl_r[0]) + TOT_W'(lvl_r[1])
                  + TOT_W'(lvl_r[2]) + TOT_W'(lvl_r[3]);
        diff_nxt  = DIFF_W'((15'(lvl_r[0]) + 15'(lvl_r[1]))
                          - (15'(lvl_r[2]) + 15'(lvl_r[3])));
        if (lvl_r == '0) begin
          filt_nxt    = '0;
          pw_nxt      = NEUTRAL_US;
          ang_out_nxt = '0;
          nf_nxt      = 1'b1;
          cen_nxt     = 1'b0;
          state_nxt   = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mprod_nxt = $signed({1'b0, total_r}) * filt_r;
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        num_nxt   = (NUM_W'(diff_r) <<< 15) + (NUM_W'(mprod_r) <<< 2) + NUM_W'(mprod_r);
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          filt_nxt  = num_r[NUM_W-1] ? ANG_W'(-div_rsp.quotient)
                                     : ANG_W'(div_rsp.quotient);
          state_nxt = ST_CMUL;
        end
      end
      ST_CMUL: begin
        gprod_nxt = $signed({1'b0, cfg.gain}) * filt_r;
        state_nxt = ST_CORR;
        if (ang_abs < ANG_W'(cfg.deadband)) begin
          if (settle_inc >= SETTLE_W'(SETTLE_TICKS)) begin
            settle_nxt  = '0;
            pw_nxt      = NEUTRAL_US;
            ang_out_nxt = filt_r;
            nf_nxt      = 1'b0;
            cen_nxt     = 1'b1;
            state_nxt   = ST_OUT;
          end else begin
            settle_nxt = settle_inc;
          end
        end else begin
          settle_nxt = '0;
        end
      end
      ST_CORR: begin
        pw_nxt      = p_neg ? (NEUTRAL_US + PW_W'(corr)) : (NEUTRAL_US - PW_W'(corr));
        ang_out_nxt = filt_r;
        nf_nxt      = 1'b0;
        cen_nxt     = 1'b0;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      filt_r   <= '0;
      settle_r <= '0;
    end else begin
      state_r  <= state_nxt;
      filt_r   <= filt_nxt;
      settle_r <= settle_nxt;
    end
  end

  // Working and result registers; levels load on the input transfer.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      lvl_r <= lvl_nxt;
    end
    total_r   <= total_nxt;
    diff_r    <= diff_nxt;
    mprod_r   <= mprod_nxt;
    num_r     <= num_nxt;
    gprod_r   <= gprod_nxt;
    pw_r      <= pw_nxt;
    ang_out_r <= ang_out_nxt;
    nf_r      <= nf_nxt;
    cen_r     <= cen_nxt;
  end

  assign out_pulse_width  = pw_r;
  assign out_angle_q8     = ang_out_r;
  assign out_flame_absent = nf_r;
  assign out_centred      = cen_r;

  // A pending result keeps the input side closed.
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  // A result without a flame is neutral with a cleared bearing.
  a_dark_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flame_absent) |->
      (out_angle_q8 == '0) && (out_pulse_width == NEUTRAL_US) && !out_centred)
    else $error("result without flame not neutral");

  // A centred result drives neutral.
  a_centred_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_centred) |-> (out_pulse_width == NEUTRAL_US) && !out_flame_absent)
    else $error("centred result not neutral");

  // The filtered bearing stays within its range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (filt_r <= ANGLE_LIM) && (filt_r >= -ANGLE_LIM))
    else $error("filtered bearing out of range");

  // The settle count restarts before it reaches the settle length.
  a_settle_range: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r < SETTLE_W'(SETTLE_TICKS))
    else $error("settle count overran");

endmodule

`default_nettype wire
